@@ sv/group_strings_by_char_set_unit_defines.svh @@
// Assertion macros shared by the character-set grouping unit.
`ifndef GROUP_STRINGS_BY_CHAR_SET_UNIT_DEFINES_SVH
`define GROUP_STRINGS_BY_CHAR_SET_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Concurrent check that is switched off while reset is high.
`define GSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Concurrent check that is also evaluated around reset.
`define GSC_ASSERT_ON(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GSC_ASSERT(lbl, clk, rst, prop, msg)
`define GSC_ASSERT_ON(lbl, clk, prop, msg)
`endif

`endif

@@ sv/gsc_pkg.sv @@
package gsc_pkg;

  // One input item.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [3:0] group_index;
    logic       new_group;
    logic       empty_string;
    logic       table_full;
  } out_item_t;

  localparam int GROUP_INDEX_W = 4;

  // Action codes of an input item.
  localparam logic [1:0] ACT_CHAR  = 2'd0;
  localparam logic [1:0] ACT_END   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Job kinds passed from the front end to the back end.
  typedef enum logic {
    CMD_END,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic empty;
  } job_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_MISS,
    B_EMIT
  } back_state_t;

endpackage

@@ sv/gsc_queue.sv @@
module gsc_queue #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == DEPTH_CNT);
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/gsc_front.sv @@
module gsc_front #(
  parameter int CHAR_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  gsc_pkg::in_item_t     item,
  output logic                  job_push,
  output gsc_pkg::job_ctl_t     job_ctl,
  output logic [(1<<CHAR_BITS)-1:0] job_mask,
  input  logic                  job_full
);
  import gsc_pkg::*;

  localparam int SET_BITS = 1 << CHAR_BITS;

  logic [SET_BITS-1:0]  mask;
  logic [SET_BITS-1:0]  mask_next;
  logic                 seen;
  logic                 seen_next;
  logic                 accept;
  logic [CHAR_BITS-1:0] ch;

  assign full     = job_full;
  assign accept   = push && !job_full;
  assign ch       = item.char_value[CHAR_BITS-1:0];
  assign job_mask = mask;

  // Characters update the open set; end and clear hand a job to the back end.
  always_comb begin
    mask_next   = mask;
    seen_next   = seen;
    job_push    = 1'b0;
    job_ctl.cmd = CMD_END;
    job_ctl.empty = !seen;
    case (item.action)
      ACT_CHAR: begin
        if (accept) begin
          mask_next[ch] = 1'b1;
          seen_next     = 1'b1;
        end
      end
      ACT_END: begin
        if (accept) begin
          job_push  = 1'b1;
          mask_next = '0;
          seen_next = 1'b0;
        end
      end
      ACT_CLEAR: begin
        job_ctl.cmd = CMD_CLEAR;
        if (accept) begin
          job_push  = 1'b1;
          mask_next = '0;
          seen_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      seen <= 1'b0;
    end else begin
      mask <= mask_next;
      seen <= seen_next;
    end
  end

endmodule

@@ sv/gsc_back.sv @@
`include "group_strings_by_char_set_unit_defines.svh"

module gsc_back #(
  parameter int MAX_GROUPS = 16,
  parameter int CHAR_BITS  = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_empty,
  input  gsc_pkg::job_ctl_t         job_ctl,
  input  logic [(1<<CHAR_BITS)-1:0] job_mask,
  output logic                      job_pop,
  output logic                      empty,
  input  logic                      pop,
  output gsc_pkg::out_item_t        result
);
  import gsc_pkg::*;

  localparam int SET_BITS = 1 << CHAR_BITS;
  localparam int IDX_W    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CNT_W    = $clog2(MAX_GROUPS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_GROUPS);

  logic [SET_BITS-1:0] key_mem [MAX_GROUPS];
  logic [SET_BITS-1:0] rd_data;

  back_state_t         state;
  back_state_t         state_next;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    idx_next;
  logic [CNT_W-1:0]    idx_ext;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  out_item_t           res;
  out_item_t           res_next;
  logic                mem_we;
  logic                out_load;
  logic                out_valid;
  logic                key_hit;
  logic                last_key;

  assign idx_ext  = CNT_W'(idx);
  assign key_hit  = (rd_data == job_mask);
  assign last_key = ((idx_ext + CNT_W'(1)) == count);
  assign empty    = !out_valid;

  // Key store: one write port at the fill count, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[count[IDX_W-1:0]] <= job_mask;
    end
    rd_data <= key_mem[idx];
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!job_empty && job_ctl.cmd == CMD_END) begin
          if (job_ctl.empty) begin
            state_next = B_EMIT;
          end else if (count == '0) begin
            state_next = B_MISS;
          end else begin
            state_next = B_READ;
          end
        end
      end
      B_READ: begin
        state_next = B_CMP;
      end
      B_CMP: begin
        if (key_hit) begin
          state_next = B_EMIT;
        end else if (last_key) begin
          state_next = B_MISS;
        end else begin
          state_next = B_READ;
        end
      end
      B_MISS: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (!out_valid || pop) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    idx_next   = idx;
    count_next = count;
    res_next   = res;
    mem_we     = 1'b0;
    job_pop    = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_IDLE: begin
        idx_next = '0;
        if (!job_empty) begin
          if (job_ctl.cmd == CMD_CLEAR) begin
            job_pop    = 1'b1;
            count_next = '0;
          end else if (job_ctl.empty) begin
            job_pop  = 1'b1;
            res_next = '{group_index: '0, new_group: 1'b0,
                         empty_string: 1'b1, table_full: 1'b0};
          end
        end
      end
      B_READ: begin
      end
      B_CMP: begin
        if (key_hit) begin
          job_pop  = 1'b1;
          res_next = '{group_index: GROUP_INDEX_W'(idx), new_group: 1'b0,
                       empty_string: 1'b0, table_full: 1'b0};
        end else if (!last_key) begin
          idx_next = idx + IDX_W'(1);
        end
      end
      B_MISS: begin
        job_pop = 1'b1;
        if (count < MAX_CNT) begin
          mem_we     = 1'b1;
          count_next = count + CNT_W'(1);
          res_next   = '{group_index: GROUP_INDEX_W'(count), new_group: 1'b1,
                         empty_string: 1'b0, table_full: 1'b0};
        end else begin
          res_next = '{group_index: '0, new_group: 1'b0,
                       empty_string: 1'b0, table_full: 1'b1};
        end
      end
      B_EMIT: begin
        out_load = !out_valid || pop;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    res <= res_next;
    if (out_load) begin
      result <= res;
    end
  end

  `GSC_ASSERT(a_count_bound, clk, rst, count <= MAX_CNT, "group count above capacity")
  `GSC_ASSERT(a_cmp_after_read, clk, rst, (state == B_CMP) |-> ($past(state) == B_READ), "compare without read")
  `GSC_ASSERT(a_read_in_range, clk, rst, (state == B_READ) |-> (idx_ext < count), "read past stored groups")
  `GSC_ASSERT(a_pop_has_job, clk, rst, job_pop |-> !job_empty, "job popped from empty queue")
  `GSC_ASSERT_ON(a_reset_idle, clk, $past(rst) |-> (state == B_IDLE && !out_valid), "not idle after reset")

endmodule

@@ sv/group_strings_by_char_set_unit.sv @@
// Channel   Handshake            Payload                      Accepted when
// input     push / full          item   (gsc_pkg::in_item_t)  push && !full
// result    empty / pop          result (gsc_pkg::out_item_t) pop && !empty
//
// A job is registered in the job queue before the back end sees it. There an
// end of string compares stored keys in turn up to a match or the last key,
// stores a missed set if room is left, then emits; an empty string skips the
// search, and a clear resets the group count. Reset (rst, synchronous) empties
// the job queue, the result register and the group count; the key store keeps
// its contents and needs no clearing pass. full rises only while the two-entry
// job queue is full, as when a finished result waits behind a held one.
module group_strings_by_char_set_unit #(
  parameter int MAX_GROUPS = 16,
  parameter int CHAR_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  gsc_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output gsc_pkg::out_item_t result
);
  import gsc_pkg::*;

  // The set of distinct byte values of a string is a one-hot-per-value mask.
  localparam int SET_BITS = 1 << CHAR_BITS;
  localparam int JOB_W    = $bits(job_ctl_t) + SET_BITS;

  logic                job_push;
  logic                job_full;
  job_ctl_t            job_ctl_in;
  logic [SET_BITS-1:0] job_mask_in;
  logic                job_pop;
  logic                job_empty;
  logic [JOB_W-1:0]    job_rd;
  job_ctl_t            job_ctl_out;
  logic [SET_BITS-1:0] job_mask_out;

  // The front end builds the mask of the open string and turns each end or
  // clear item into a job for the back end.
  gsc_front #(
    .CHAR_BITS (CHAR_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_push (job_push),
    .job_ctl  (job_ctl_in),
    .job_mask (job_mask_in),
    .job_full (job_full)
  );

  // Jobs keep their order, so a clear never overtakes a pending search.
  gsc_queue #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data ({job_ctl_in, job_mask_in}),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  assign job_ctl_out  = job_ctl_t'(job_rd[JOB_W-1:SET_BITS]);
  assign job_mask_out = job_rd[SET_BITS-1:0];

  // The back end walks the stored group keys in order of first appearance,
  // so the first match is the lowest group number, and stores new keys.
  gsc_back #(
    .MAX_GROUPS (MAX_GROUPS),
    .CHAR_BITS  (CHAR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_ctl   (job_ctl_out),
    .job_mask  (job_mask_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

@@ verif/tb_group_strings_by_char_set_unit.sv @@
`timescale 1ns / 1ps

module tb_group_strings_by_char_set_unit;

  import gsc_pkg::*;

  // Block configuration under test. These match the defaults of the unit.
  localparam int MAX_GROUPS = 16;
  localparam int CHAR_BITS  = 8;

  // Only the low CHAR_BITS of a character take part in the set.
  localparam logic [7:0] CHAR_MASK = 8'((1 << CHAR_BITS) - 1);

  // The one action code that the package does not name. The unit must
  // swallow it without a result and without touching its state.
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  // An end of string searches at most MAX_GROUPS keys. The settle time at
  // the end covers that search with room to spare.
  localparam int SETTLE_CYCLES = 4 * (3 + 2 * MAX_GROUPS);

  // Cycles in a row with no item moving on either side before the run is
  // declared hung. The longest legal quiet stretch is the deliberate
  // receiver hold-off in the back-pressure test.
  localparam int QUIET_LIMIT = 20000;

  // Length of the deliberate receiver hold-off in the back-pressure test.
  localparam int LONG_HOLD_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;

  group_strings_by_char_set_unit #(
    .MAX_GROUPS(MAX_GROUPS),
    .CHAR_BITS (CHAR_BITS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  // 2 ns clock: one delay for each half of the period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the grouping state.
  // The set of the open string, whether it has any character yet, and the
  // list of sets that have been given a group number so far.
  // ---------------------------------------------------------------------
  logic [255:0] open_set = '0;
  bit           open_nonempty = 1'b0;
  logic [255:0] known_sets [MAX_GROUPS];
  int unsigned  known_count = 0;

  // Group labels that the unit still owes us, oldest first.
  out_item_t pending_labels [$];

  // Idle rates in percent for each side, and a count of cycles for which
  // the receiver must refuse results no matter what its rate says.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;

  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Advance the shadow state by one accepted item and queue the label
  // that an end of string must produce.
  task automatic track_char_sets(input in_item_t it);
    out_item_t   lbl;
    int          hit_at;
    logic [7:0]  ch;
    ch = it.char_value & CHAR_MASK;
    case (it.action)
      ACT_CHAR: begin
        open_set[ch] = 1'b1;
        open_nonempty = 1'b1;
      end
      ACT_CLEAR: begin
        // Forget every group and whatever part of a string was open.
        open_set = '0;
        open_nonempty = 1'b0;
        known_count = 0;
      end
      ACT_END: begin
        lbl = '0;
        if (!open_nonempty) begin
          // An empty string gets no group; only its flag is raised.
          lbl.empty_string = 1'b1;
        end else begin
          hit_at = -1;
          for (int g = 0; g < known_count; g++) begin
            if (hit_at < 0 && known_sets[g] == open_set) hit_at = g;
          end
          if (hit_at >= 0) begin
            lbl.group_index = GROUP_INDEX_W'(hit_at);
          end else if (known_count < MAX_GROUPS) begin
            // A new set takes the next group number in order of arrival.
            known_sets[known_count] = open_set;
            lbl.group_index = GROUP_INDEX_W'(known_count);
            lbl.new_group = 1'b1;
            known_count++;
          end else begin
            // No room left: the string is flagged and nothing is stored.
            lbl.table_full = 1'b1;
          end
        end
        pending_labels = {pending_labels, lbl};
        open_set = '0;
        open_nonempty = 1'b0;
      end
      default: begin
        // The spare action code is ignored entirely.
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [3:0] got,
                             input logic [3:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Offer one item to the unit. Inputs change on the falling edge only;
  // the item counts as taken at the first rising edge with full low.
  // Push stays high on return so that back-to-back items leave no gap; any
  // caller that stops sending must go through wait_for_labels.
  task automatic send_item(input logic [1:0] act, input logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    item = '{action: act, char_value: ch};
    push = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    track_char_sets(item);
  endtask

  // Stop sending and wait until every label owed has been taken.
  task automatic wait_for_labels();
    @(negedge clk);
    push = 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver side. Pop is decided on the falling edge from the current idle
  // rate, or held low while a long hold-off is counting down.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      pop = 1'b0;
      recv_hold--;
    end else begin
      pop = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result taken is matched against the oldest label still owed.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_labels.size() == 0) begin
        report_mismatch($sformatf("result %p arrived with none expected", result));
      end else begin
        want = pending_labels.pop_front();
        check_field("group_index", result.group_index, want.group_index);
        check_field("new_group", 4'(result.new_group), 4'(want.new_group));
        check_field("empty_string", 4'(result.empty_string), 4'(want.empty_string));
        check_field("table_full", 4'(result.table_full), 4'(want.table_full));
      end
    end
  end

  // Watchdog: the run is hung if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_group_strings_by_char_set_unit failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Empty strings, straight after reset and again after an ignored item.
  task automatic test_empty_strings();
    send_item(ACT_END, 8'h00);
    send_item(ACT_IGNORED, 8'hFF);
    send_item(ACT_END, 8'hA5);
  endtask

  // Byte values at both ends and on each 64-bit word boundary of the set.
  // The second string repeats the first set in another order and with a
  // duplicate, so it must land in the same group.
  task automatic test_byte_extremes();
    send_item(ACT_CHAR, 8'h00);
    send_item(ACT_CHAR, 8'hFF);
    send_item(ACT_END, 8'h00);
    send_item(ACT_CHAR, 8'hFF);
    send_item(ACT_CHAR, 8'h00);
    send_item(ACT_IGNORED, 8'h55);
    send_item(ACT_CHAR, 8'h00);
    send_item(ACT_END, 8'hFF);
    send_item(ACT_CHAR, 8'h3F);
    send_item(ACT_CHAR, 8'h40);
    send_item(ACT_END, 8'h00);
    send_item(ACT_CHAR, 8'h7F);
    send_item(ACT_CHAR, 8'h80);
    send_item(ACT_CHAR, 8'hBF);
    send_item(ACT_CHAR, 8'hC0);
    send_item(ACT_END, 8'h00);
  endtask

  // A clear in the middle of a string drops the partial set as well as the
  // groups, so the following end is empty and the old set opens group 0.
  task automatic test_clear_midstring();
    send_item(ACT_CHAR, 8'h41);
    send_item(ACT_CHAR, 8'h42);
    send_item(ACT_CLEAR, 8'h41);
    send_item(ACT_END, 8'h00);
    send_item(ACT_CHAR, 8'hFF);
    send_item(ACT_CHAR, 8'h00);
    send_item(ACT_END, 8'h00);
  endtask

  // Fill every group with a one-character set, overflow with one more,
  // then check that a stored set still matches once the table is full.
  task automatic test_table_full();
    logic [7:0] base;
    base = 8'($urandom);
    send_item(ACT_CLEAR, 8'h00);
    for (int k = 0; k <= MAX_GROUPS; k++) begin
      send_item(ACT_CHAR, base + 8'(k));
      send_item(ACT_END, 8'($urandom));
    end
    send_item(ACT_CHAR, base + 8'd3);
    send_item(ACT_END, 8'($urandom));
  endtask

  // The receiver refuses results for a long stretch while the sender keeps
  // offering strings, so the unit's queues fill and full must rise. Then
  // the sender waits for every label before going on.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = LONG_HOLD_CYCLES;
    for (int k = 0; k < 20; k++) begin
      if (k % 3 != 0) send_item(ACT_CHAR, 8'($urandom_range(3)));
      send_item(ACT_END, 8'($urandom));
    end
    wait_for_labels();
  endtask

  // Mostly well-formed strings drawn from a small alphabet so that sets
  // repeat and the table fills between clears, with a sprinkle of foreign
  // bytes, clears, strings cut short by a clear, and ignored items.
  task automatic run_random_strings(input int budget, input int tx_idle,
                                    input int rx_idle);
    logic [7:0] alphabet [6];
    int         sent;
    int         len;
    int         roll;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    foreach (alphabet[k]) alphabet[k] = 8'($urandom);
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_item(ACT_CLEAR, 8'($urandom));
        sent++;
        foreach (alphabet[k]) alphabet[k] = 8'($urandom);
      end else if (roll < 6) begin
        send_item(ACT_IGNORED, 8'($urandom));
      end else begin
        len = $urandom_range(6);
        repeat (len) begin
          send_item(ACT_CHAR, ($urandom_range(9) == 0) ? 8'($urandom)
                                                      : alphabet[$urandom_range(5)]);
          sent++;
        end
        if (roll < 12) begin
          send_item(ACT_CLEAR, 8'($urandom));
          foreach (alphabet[k]) alphabet[k] = 8'($urandom);
        end else begin
          send_item(ACT_END, 8'($urandom));
        end
        sent++;
      end
    end
    wait_for_labels();
  endtask

  // ---------------------------------------------------------------------
  // Sequence of the run. Reset is released on a falling edge; the directed
  // tests run with the receiver ready outside the stall test's hold-off,
  // then the random part walks through the three idle patterns.
  // ---------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_strings();
    test_byte_extremes();
    test_clear_midstring();
    wait_for_labels();
    test_table_full();
    wait_for_labels();
    test_output_stall();

    run_random_strings(650, 8, 56);
    run_random_strings(650, 56, 8);
    run_random_strings(650, 0, 0);

    // Give the unit time to emit anything stray before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_group_strings_by_char_set_unit passed");
    end else begin
      $display("tb_group_strings_by_char_set_unit failed");
    end
    $finish;
  end

endmodule
